// ----- rtl/grc_pkg.sv -----
`default_nettype none
package grc_pkg;

   localparam int MAP_DIM    = 64;
   localparam int MAP_BITS   = $clog2(MAP_DIM);
   localparam int ADDR_W     = 2 * MAP_BITS;
   localparam int CODE_BITS  = 8;
   localparam int DIM_W      = 7;
   localparam int POS_W      = 22;
   localparam int FRAC_W     = 16;
   localparam int DIR_W      = 16;
   localparam int RECIP_W    = 31;
   localparam int DIFF_W     = FRAC_W + 1;
   localparam int DIST_W     = 37;
   localparam int LO_W       = 19;
   localparam int HI_W       = DIST_W - LO_W;
   localparam int PROD_W     = DIR_W + DIST_W;
   localparam int Q_W        = PROD_W - 14;
   localparam int C_W        = Q_W + 3;
   localparam int LINE_W     = 9;
   localparam int OUT_DIST_W = 24;
   localparam int STEP_W     = DIM_W;
   localparam int DIV_STEPS  = RECIP_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAP_DIM);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_FIRST,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_POS,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MAP_BITS-1:0]  cell_x;
      logic [MAP_BITS-1:0]  cell_y;
      logic [CODE_BITS-1:0] cell_code;
      logic [POS_W-1:0]     origin_x;
      logic [POS_W-1:0]     origin_y;
      logic [DIR_W-1:0]     dir_x;
      logic [DIR_W-1:0]     dir_y;
   } req_fields_type;

   typedef struct packed {
      logic                 clear_en;
      logic [ADDR_W-1:0]    clr_addr;
      logic                 cell_wr;
      logic                 load_req;
      logic                 vert;
      logic                 setup;
      logic                 div_step;
      logic                 first_mul;
      logic                 mul_lo;
      logic                 mul_hi;
      logic                 pos;
      logic                 record;
      logic                 advance;
      logic                 load_rsp;
   } cmd_type;

   typedef struct packed {
      logic                 dir_zero;
      logic                 stop;
      logic                 solid;
      logic                 rsp_busy;
      logic [DIM_W-1:0]     limit;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/grid_ray_cast.sv -----
// grid ray caster over a 64 x 64 map of wall codes
// sequence: a cell write is taken in the idle state; a cast runs, per pass with a non-zero
//   step component, setup, the 31-step reciprocal divider and the first distance, then per
//   grid line crossed two partial multiplies, position and map read; a zero-step pass is skipped
// flow: one request word at a time; a cast ends by loading the result once the response is free
// reset: synchronous; registers return to 64, map cleared with req_tready low
`default_nettype none
module grid_ray_cast (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // cell_x, cell_y, cell_code, origin_x, origin_y, dir_x, dir_y
   input  wire  [95:0]  req_tdata,
   // req_type
   input  wire          req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // hit, hit_x, hit_y, distance, was_vertical, wall_code, zero pad
   output logic [79:0]  rsp_tdata,
   input  wire          csr_we,
   input  wire          csr_addr,
   input  wire  [6:0]   csr_wdata
);
   import grc_pkg::*;

   cmd_type        cmd;
   sts_type        sts;
   req_fields_type req;

   assign req.cell_x    = req_tdata[5:0];
   assign req.cell_y    = req_tdata[11:6];
   assign req.cell_code = req_tdata[19:12];
   assign req.origin_x  = req_tdata[41:20];
   assign req.origin_y  = req_tdata[63:42];
   assign req.dir_x     = req_tdata[79:64];
   assign req.dir_y     = req_tdata[95:80];

   grc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   grc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req        (req),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- rtl/grc_datapath.sv -----
`default_nettype none
module grc_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire grc_pkg::cmd_type        cmd,
   output grc_pkg::sts_type             sts,
   input  wire grc_pkg::req_fields_type req,
   input  wire                          csr_we,
   input  wire                          csr_addr,
   input  wire  [grc_pkg::DIM_W-1:0]    csr_wdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [79:0]                  rsp_tdata
);
   import grc_pkg::*;

   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [DIM_W-1:0]     w_eff, h_eff, dim_a, dim_c;

   logic [CODE_BITS-1:0] mem [MAP_DIM*MAP_DIM];
   logic [CODE_BITS-1:0] rd_ff;
   logic [ADDR_W-1:0]    raddr;

   logic [POS_W-1:0]     ox_ff, oy_ff;
   logic [DIR_W-1:0]     dx_ff, dy_ff;
   logic [POS_W-1:0]     pa, pc;
   logic [DIR_W-1:0]     da, dc;

   logic [DIR_W-1:0]     mag_ff, mc_ff;
   logic                 neg_ff, dcneg_ff;
   logic [DIR_W-1:0]     rem_ff;
   logic [RECIP_W-1:0]   dvd_ff;
   logic [DIFF_W-1:0]    diff_ff;
   logic signed [LINE_W-1:0] line_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [DIR_W+LO_W-1:0] pl_ff;
   logic [PROD_W-1:0]    pr_ff;
   logic                 stop_ff, cav_ff;
   logic [POS_W-1:0]     c_ff;

   logic                 hit_ff, hvert_ff;
   logic [POS_W-1:0]     hx_ff, hy_ff;
   logic [DIST_W-1:0]    hdist_ff;
   logic [CODE_BITS-1:0] hcode_ff;

   logic                 rsp_valid_ff;
   logic [79:0]          rsp_data_ff;

   logic [DIR_W-1:0]     mag_c, mc_c;
   logic [DIFF_W:0]      rem_sh;
   logic                 qbit;
   logic [DIFF_W+RECIP_W-1:0] first_prod;
   logic [Q_W:0]         q_rnd;
   logic signed [C_W-1:0] q_s, c_s;
   logic                 inb, early;
   logic signed [LINE_W-1:0] ca;
   logic [POS_W-1:0]     g_pos;
   logic [OUT_DIST_W-1:0] dist_sat;

   assign w_eff = (width_ff > DIM_RESET) ? DIM_RESET : width_ff;
   assign h_eff = (height_ff > DIM_RESET) ? DIM_RESET : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAP_WIDTH:  width_ff  <= csr_wdata;
            CSR_MAP_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pass select: horizontal lines step along y, vertical along x
   assign pa    = cmd.vert ? ox_ff : oy_ff;
   assign pc    = cmd.vert ? oy_ff : ox_ff;
   assign da    = cmd.vert ? dx_ff : dy_ff;
   assign dc    = cmd.vert ? dy_ff : dx_ff;
   assign dim_a = cmd.vert ? w_eff : h_eff;
   assign dim_c = cmd.vert ? h_eff : w_eff;

   assign mag_c = da[DIR_W-1] ? (~da + 1'b1) : da;
   assign mc_c  = dc[DIR_W-1] ? (~dc + 1'b1) : dc;

   assign rem_sh = {1'b0, rem_ff, dvd_ff[RECIP_W-1]};
   assign qbit   = (rem_sh >= {2'b0, mag_ff});

   assign first_prod = diff_ff * dvd_ff;

   // floor of signed product over 2^14, done on the magnitude
   assign q_rnd = {1'b0, pr_ff[PROD_W-1:14]} + {{Q_W{1'b0}}, |pr_ff[13:0]};
   assign q_s   = dcneg_ff ? -$signed({2'b0, q_rnd}) : $signed({3'b0, pr_ff[PROD_W-1:14]});
   assign c_s   = $signed({{(C_W-POS_W){1'b0}}, pc}) + q_s;

   assign inb = !line_ff[LINE_W-1] && (line_ff[LINE_W-2:0] < {1'b0, dim_a})
             && !c_s[C_W-1]
             && (c_s[C_W-2:FRAC_W] < {{(C_W-1-FRAC_W-DIM_W){1'b0}}, dim_c});
   assign early = cmd.vert && hit_ff && (dist_ff > hdist_ff);
   assign ca    = neg_ff ? line_ff - 1'b1 : line_ff;
   assign raddr = cmd.vert ? {c_s[FRAC_W+MAP_BITS-1:FRAC_W], ca[MAP_BITS-1:0]}
                           : {ca[MAP_BITS-1:0], c_s[FRAC_W+MAP_BITS-1:FRAC_W]};
   assign g_pos = {line_ff[MAP_BITS-1:0], {FRAC_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[cmd.clr_addr] <= '0;
      end else if (cmd.cell_wr) begin
         mem[{req.cell_y, req.cell_x}] <= req.cell_code;
      end
      if (cmd.pos) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         ox_ff <= req.origin_x;
         oy_ff <= req.origin_y;
         dx_ff <= req.dir_x;
         dy_ff <= req.dir_y;
      end
      if (cmd.setup) begin
         mag_ff   <= mag_c;
         mc_ff    <= mc_c;
         neg_ff   <= da[DIR_W-1];
         dcneg_ff <= dc[DIR_W-1];
         rem_ff   <= '0;
         dvd_ff   <= {1'b1, {(RECIP_W-1){1'b0}}};
         if (da[DIR_W-1]) begin
            line_ff <= $signed({{(LINE_W-MAP_BITS){1'b0}}, pa[POS_W-1:FRAC_W]});
            diff_ff <= {1'b0, pa[FRAC_W-1:0]};
         end else begin
            line_ff <= $signed({{(LINE_W-MAP_BITS){1'b0}}, pa[POS_W-1:FRAC_W]}) + 1'b1;
            diff_ff <= {1'b1, {FRAC_W{1'b0}}} - {1'b0, pa[FRAC_W-1:0]};
         end
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? DIR_W'(rem_sh - {2'b0, mag_ff}) : rem_sh[DIR_W-1:0];
         dvd_ff <= {dvd_ff[RECIP_W-2:0], qbit};
      end
      if (cmd.first_mul) begin
         dist_ff <= DIST_W'(first_prod[DIFF_W+RECIP_W-1:FRAC_W]);
      end
      if (cmd.mul_lo) begin
         pl_ff <= mc_ff * dist_ff[LO_W-1:0];
      end
      if (cmd.mul_hi) begin
         pr_ff <= {((DIR_W+HI_W)'(mc_ff) * dist_ff[DIST_W-1:LO_W]), {LO_W{1'b0}}}
                + {{(PROD_W-DIR_W-LO_W){1'b0}}, pl_ff};
      end
      if (cmd.pos) begin
         stop_ff <= !inb || early;
         cav_ff  <= !ca[LINE_W-1];
         c_ff    <= c_s[POS_W-1:0];
      end
      if (cmd.advance) begin
         line_ff <= neg_ff ? line_ff - 1'b1 : line_ff + 1'b1;
         dist_ff <= dist_ff + DIST_W'(dvd_ff);
      end
      if (cmd.record) begin
         hx_ff    <= cmd.vert ? g_pos : c_ff;
         hy_ff    <= cmd.vert ? c_ff : g_pos;
         hdist_ff <= dist_ff;
         hvert_ff <= cmd.vert;
         hcode_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.load_req) begin
         hit_ff <= 1'b0;
      end else if (cmd.record) begin
         hit_ff <= 1'b1;
      end
   end

   assign dist_sat = (|hdist_ff[DIST_W-1:OUT_DIST_W]) ? '1 : hdist_ff[OUT_DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {2'b00,
                         hit_ff ? hcode_ff : {CODE_BITS{1'b0}},
                         hit_ff & hvert_ff,
                         hit_ff ? dist_sat : {OUT_DIST_W{1'b1}},
                         hit_ff ? hy_ff : oy_ff,
                         hit_ff ? hx_ff : ox_ff,
                         hit_ff};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.dir_zero = (da == '0);
   assign sts.stop     = stop_ff;
   assign sts.solid    = cav_ff && (rd_ff != '0);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign sts.limit    = dim_a;

endmodule
`default_nettype wire

// ----- rtl/grc_ctrl.sv -----
`default_nettype none
module grc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire                    req_tuser,
   output grc_pkg::cmd_type       cmd,
   input  wire grc_pkg::sts_type  sts
);
   import grc_pkg::*;

   state_type             state_ff, state_in;
   logic                  pass_ff, pass_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [STEP_W-1:0]     step_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pass_ff  <= 1'b0;
         step_ff  <= '0;
         dcnt_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         step_ff  <= step_in;
         dcnt_ff  <= dcnt_in;
         clr_ff   <= clr_in;
      end
   end

   assign step_nx = step_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      step_in      = step_ff;
      dcnt_in      = dcnt_ff;
      clr_in       = clr_ff;
      cmd          = '0;
      cmd.vert     = pass_ff;
      cmd.clr_addr = clr_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == REQ_CAST) begin
                  cmd.load_req = 1'b1;
                  pass_in = 1'b0;
                  state_in = ST_SETUP;
               end else begin
                  cmd.cell_wr = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            if (sts.dir_zero) begin
               if (pass_ff) begin
                  state_in = ST_DONE;
               end else begin
                  pass_in = 1'b1;
               end
            end else begin
               cmd.setup = 1'b1;
               dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.first_mul = 1'b1;
            step_in = '0;
            if (sts.limit == '0) begin
               if (pass_ff) state_in = ST_DONE;
               else begin
                  pass_in = 1'b1;
                  state_in = ST_SETUP;
               end
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            cmd.pos = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            // leave the pass on out of bounds, early stop, a solid cell or the last line
            if (!sts.stop && !sts.solid && (step_nx < sts.limit)) begin
               cmd.advance = 1'b1;
               step_in = step_nx;
               state_in = ST_MUL_LO;
            end else begin
               if (!sts.stop && sts.solid) begin
                  cmd.record = 1'b1;
               end else if (!sts.stop) begin
                  cmd.advance = 1'b1;
               end
               if (pass_ff) state_in = ST_DONE;
               else begin
                  pass_in = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire
